// ----- sv/aprs_position_line_parser_core_assert.svh -----
// Assertion macros for the position line parser.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef APRS_POSITION_LINE_PARSER_CORE_ASSERT_SVH
`define APRS_POSITION_LINE_PARSER_CORE_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define APRSP_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define APRSP_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define APRSP_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/aprsp_pkg.sv -----
// Shared types and constants for the position line parser.
// No dependencies.
`timescale 1ns / 1ps

package aprsp_pkg;

    localparam int CS_COUNT_W = 4;
    localparam int CS_SLOTS   = 10;
    localparam int POS_OFF_W  = 5;

    localparam logic [7:0] LINE_END    = 8'h0a;
    localparam logic [7:0] CHAR_HASH   = 8'h23;
    localparam logic [7:0] CHAR_GT     = 8'h3e;
    localparam logic [7:0] CHAR_COLON  = 8'h3a;
    localparam logic [7:0] CHAR_EQUAL  = 8'h3d;
    localparam logic [7:0] CHAR_SOUTH  = 8'h53;
    localparam logic [7:0] CHAR_WEST   = 8'h57;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    // Offsets within the 18 position bytes after ":="
    localparam logic [POS_OFF_W-1:0] POS_BYTES     = 5'd18;
    localparam logic [POS_OFF_W-1:0] OFF_LAT_DEG   = 5'd0;
    localparam logic [POS_OFF_W-1:0] OFF_LAT_MIN   = 5'd2;
    localparam logic [POS_OFF_W-1:0] OFF_LAT_HUN   = 5'd5;
    localparam logic [POS_OFF_W-1:0] OFF_LAT_HEMI  = 5'd7;
    localparam logic [POS_OFF_W-1:0] OFF_LON_DEG   = 5'd9;
    localparam logic [POS_OFF_W-1:0] OFF_LON_MIN   = 5'd12;
    localparam logic [POS_OFF_W-1:0] OFF_LON_HUN   = 5'd15;
    localparam logic [POS_OFF_W-1:0] OFF_LON_HEMI  = 5'd17;

    // floor(h * 3 / 5) == (h * 615) >> 10 for h in 0..99
    localparam logic [9:0] SEC_MUL   = 10'd615;
    localparam int         SEC_SHIFT = 10;

    typedef struct packed {
        logic clear;
        logic push;
    } cs_ctl_t;

    typedef struct packed {
        logic                 clear;
        logic                 step;
        logic [POS_OFF_W-1:0] offset;
    } pos_ctl_t;

endpackage

// ----- sv/aprs_position_line_parser_core.sv -----
// Takes one text byte per item and gives one result item per valid APRS position line:
// callsign (up to MAX_CALLSIGN_BYTES bytes, truncation flagged) and the decoded latitude
// and longitude after ":=". Lines end at 0x0a; lines starting with '#' give nothing, and
// so does a line whose ":=" comes before '>' or is followed by fewer than 18 bytes. A byte
// is accepted every cycle while the result register is free or being taken; the result
// of a line is loaded into the result register, which drives the outputs, as its 0x0a
// leaves the input register, when that register is free or being taken. Output stall
// reaches in_stall combinationally through the input register.
// Depends on aprsp_pkg, aprsp_callsign, aprsp_position and the assertion macro header.
`timescale 1ns / 1ps
`include "aprs_position_line_parser_core_assert.svh"

module aprs_position_line_parser_core #(
    parameter int MAX_CALLSIGN_BYTES = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          data_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [63:0]         callsign_head,
    output logic [15:0]         callsign_tail,
    output logic [3:0]          callsign_length,
    output logic                callsign_truncated,
    output logic signed [7:0]   latitude_degrees,
    output logic [6:0]          latitude_minutes,
    output logic [5:0]          latitude_seconds,
    output logic signed [10:0]  longitude_degrees,
    output logic [6:0]          longitude_minutes,
    output logic [5:0]          longitude_seconds
);
    import aprsp_pkg::*;

    // input register
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;

    // line control
    logic                 start_reg,   start_next;
    logic                 skip_reg,    skip_next;
    logic                 closed_reg,  closed_next;
    logic                 colon_reg,   colon_next;
    logic                 marker_reg,  marker_next;
    logic [POS_OFF_W-1:0] offset_reg,  offset_next;

    logic     out_valid_reg, out_valid_next;
    logic     out_free;
    logic     advance;
    logic     is_end;
    logic     skipping;
    logic     active;
    logic     marker_hit;
    logic     load;
    cs_ctl_t  cs_ctl;
    pos_ctl_t pos_ctl;

    logic [63:0]               cs_head;
    logic [15:0]               cs_tail;
    logic [CS_COUNT_W-1:0]     cs_length;
    logic                      cs_truncated;
    logic signed [7:0]         lat_deg;
    logic [6:0]                lat_min;
    logic [5:0]                lat_sec;
    logic signed [10:0]        lon_deg;
    logic [6:0]                lon_min;
    logic [5:0]                lon_sec;

    logic [63:0]        callsign_head_reg;
    logic [15:0]        callsign_tail_reg;
    logic [3:0]         callsign_length_reg;
    logic               callsign_truncated_reg;
    logic signed [7:0]  latitude_degrees_reg;
    logic [6:0]         latitude_minutes_reg;
    logic [5:0]         latitude_seconds_reg;
    logic signed [10:0] longitude_degrees_reg;
    logic [6:0]         longitude_minutes_reg;
    logic [5:0]         longitude_seconds_reg;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;

    assign s1_valid_next = (in_valid && !in_stall) ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s1_byte_reg <= data_byte;
    end

    assign is_end     = (s1_byte_reg == LINE_END);
    assign skipping   = skip_reg || (start_reg && (s1_byte_reg == CHAR_HASH));
    assign active     = advance && !is_end && !skipping;
    assign marker_hit = active && !marker_reg && colon_reg && (s1_byte_reg == CHAR_EQUAL);
    assign load       = advance && is_end && !skip_reg && marker_reg && (offset_reg >= POS_BYTES);

    assign cs_ctl.clear = advance && is_end;
    assign cs_ctl.push  = active && !marker_reg && !marker_hit && !closed_reg &&
                          (s1_byte_reg != CHAR_GT);

    assign pos_ctl.clear  = advance && is_end;
    assign pos_ctl.step   = active && marker_reg && (offset_reg < POS_BYTES);
    assign pos_ctl.offset = offset_reg;

    always_comb
    begin
        start_next  = start_reg;
        skip_next   = skip_reg;
        closed_next = closed_reg;
        colon_next  = colon_reg;
        marker_next = marker_reg;
        offset_next = offset_reg;
        if (advance && is_end)
        begin
            start_next  = 1'b1;
            skip_next   = 1'b0;
            closed_next = 1'b0;
            colon_next  = 1'b0;
            marker_next = 1'b0;
            offset_next = '0;
        end
        else if (advance)
        begin
            start_next = 1'b0;
            if (skipping)
                skip_next = 1'b1;
            if (pos_ctl.step)
                offset_next = offset_reg + 1'b1;
            if (active && !marker_reg)
            begin
                colon_next = (s1_byte_reg == CHAR_COLON);
                if (marker_hit)
                begin
                    // marker before '>' drops the line
                    if (closed_reg)
                        marker_next = 1'b1;
                    else
                        skip_next = 1'b1;
                end
                else if (!closed_reg && (s1_byte_reg == CHAR_GT))
                    closed_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= 1'b1;
            skip_reg   <= 1'b0;
            closed_reg <= 1'b0;
            colon_reg  <= 1'b0;
            marker_reg <= 1'b0;
            offset_reg <= '0;
        end
        else
        begin
            start_reg  <= start_next;
            skip_reg   <= skip_next;
            closed_reg <= closed_next;
            colon_reg  <= colon_next;
            marker_reg <= marker_next;
            offset_reg <= offset_next;
        end
    end

    aprsp_callsign #(
        .MAX_CALLSIGN_BYTES (MAX_CALLSIGN_BYTES)
    ) u_callsign (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (cs_ctl),
        .data_byte (s1_byte_reg),
        .head      (cs_head),
        .tail      (cs_tail),
        .length    (cs_length),
        .truncated (cs_truncated)
    );

    aprsp_position u_position (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (pos_ctl),
        .data_byte   (s1_byte_reg),
        .lat_degrees (lat_deg),
        .lat_minutes (lat_min),
        .lat_seconds (lat_sec),
        .lon_degrees (lon_deg),
        .lon_minutes (lon_min),
        .lon_seconds (lon_sec)
    );

    // result register
    assign out_valid_next = load ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            callsign_head_reg      <= cs_head;
            callsign_tail_reg      <= cs_tail;
            callsign_length_reg    <= cs_length;
            callsign_truncated_reg <= cs_truncated;
            latitude_degrees_reg   <= lat_deg;
            latitude_minutes_reg   <= lat_min;
            latitude_seconds_reg   <= lat_sec;
            longitude_degrees_reg  <= lon_deg;
            longitude_minutes_reg  <= lon_min;
            longitude_seconds_reg  <= lon_sec;
        end
    end

    assign out_valid          = out_valid_reg;
    assign callsign_head      = callsign_head_reg;
    assign callsign_tail      = callsign_tail_reg;
    assign callsign_length    = callsign_length_reg;
    assign callsign_truncated = callsign_truncated_reg;
    assign latitude_degrees   = latitude_degrees_reg;
    assign latitude_minutes   = latitude_minutes_reg;
    assign latitude_seconds   = latitude_seconds_reg;
    assign longitude_degrees  = longitude_degrees_reg;
    assign longitude_minutes  = longitude_minutes_reg;
    assign longitude_seconds  = longitude_seconds_reg;

    `APRSP_ALWAYS(a_offset_bound, offset_reg <= POS_BYTES, "position offset past 18")
    `APRSP_IMPLY(a_marker_closed, marker_reg, closed_reg && !skip_reg,
                 "marker found without closed callsign or on skipped line")
    `APRSP_ALWAYS(a_cs_length, cs_length <= CS_COUNT_W'(MAX_CALLSIGN_BYTES),
                  "callsign count beyond limit")
    `APRSP_NEXT(a_line_cleared, advance && is_end,
                start_reg && !marker_reg && !skip_reg && offset_reg == '0,
                "line state not cleared after line end")

endmodule

// ----- sv/aprsp_callsign.sv -----
// Callsign store: keeps the bytes before '>' and flags truncation.
// Depends on aprsp_pkg.
`timescale 1ns / 1ps

module aprsp_callsign #(
    parameter int MAX_CALLSIGN_BYTES = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  aprsp_pkg::cs_ctl_t                  ctl,
    input  logic [7:0]                          data_byte,
    output logic [63:0]                         head,
    output logic [15:0]                         tail,
    output logic [aprsp_pkg::CS_COUNT_W-1:0]    length,
    output logic                                truncated
);
    import aprsp_pkg::*;

    logic [7:0]            store_reg [MAX_CALLSIGN_BYTES];
    logic [CS_COUNT_W-1:0] count_reg;
    logic [CS_COUNT_W-1:0] count_next;
    logic                  overflow_reg;
    logic                  overflow_next;
    logic                  room;
    logic [7:0]            slot [CS_SLOTS];

    assign room = (count_reg < CS_COUNT_W'(MAX_CALLSIGN_BYTES));

    always_comb
    begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        if (ctl.clear)
        begin
            count_next    = '0;
            overflow_next = 1'b0;
        end
        else if (ctl.push)
        begin
            if (room)
                count_next = count_reg + 1'b1;
            else
                overflow_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < CS_SLOTS; i++)
        begin : g_slot
            if (i < MAX_CALLSIGN_BYTES)
            begin : g_kept
                always_ff @(posedge clk)
                begin
                    if (!ctl.clear && ctl.push && (count_reg == CS_COUNT_W'(i)))
                        store_reg[i] <= data_byte;
                end
                // zero the slots past the count of this line
                assign slot[i] = (CS_COUNT_W'(i) < count_reg) ? store_reg[i] : 8'h00;
            end
            else
            begin : g_unused
                assign slot[i] = 8'h00;
            end
        end
    endgenerate

    assign head      = {slot[0], slot[1], slot[2], slot[3],
                        slot[4], slot[5], slot[6], slot[7]};
    assign tail      = {slot[8], slot[9]};
    assign length    = count_reg;
    assign truncated = overflow_reg;

endmodule

// ----- sv/aprsp_position.sv -----
// Position decoder: accumulates the 18 bytes after ":=" and formats them.
// Depends on aprsp_pkg.
`timescale 1ns / 1ps

module aprsp_position (
    input  logic                clk,
    input  logic                rst_n,
    input  aprsp_pkg::pos_ctl_t ctl,
    input  logic [7:0]          data_byte,
    output logic signed [7:0]   lat_degrees,
    output logic [6:0]          lat_minutes,
    output logic [5:0]          lat_seconds,
    output logic signed [10:0]  lon_degrees,
    output logic [6:0]          lon_minutes,
    output logic [5:0]          lon_seconds
);
    import aprsp_pkg::*;

    logic       stopped_reg,  stopped_next;
    logic [6:0] lat_deg_reg,  lat_deg_next;
    logic [6:0] lat_min_reg,  lat_min_next;
    logic [6:0] lat_hun_reg,  lat_hun_next;
    logic       south_reg,    south_next;
    logic [9:0] lon_deg_reg,  lon_deg_next;
    logic [6:0] lon_min_reg,  lon_min_next;
    logic [6:0] lon_hun_reg,  lon_hun_next;
    logic       west_reg,     west_next;

    logic        is_digit;
    logic [3:0]  digit;
    logic        field_start;
    logic        stop_now;
    logic        take;
    logic [16:0] lat_sec_prod;
    logic [16:0] lon_sec_prod;

    function automatic logic [9:0] dec_acc(input logic [9:0] acc, input logic [3:0] d);
        return 10'(acc * 10'd10 + {6'd0, d});
    endfunction

    assign is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
    assign digit    = 4'(data_byte - CHAR_ZERO);

    assign field_start = (ctl.offset == OFF_LAT_DEG) || (ctl.offset == OFF_LAT_MIN) ||
                         (ctl.offset == OFF_LAT_HUN) || (ctl.offset == OFF_LON_DEG) ||
                         (ctl.offset == OFF_LON_MIN) || (ctl.offset == OFF_LON_HUN);
    assign stop_now    = field_start ? 1'b0 : stopped_reg;
    assign take        = !stop_now && is_digit;

    always_comb
    begin
        stopped_next = stopped_reg;
        lat_deg_next = lat_deg_reg;
        lat_min_next = lat_min_reg;
        lat_hun_next = lat_hun_reg;
        south_next   = south_reg;
        lon_deg_next = lon_deg_reg;
        lon_min_next = lon_min_reg;
        lon_hun_next = lon_hun_reg;
        west_next    = west_reg;
        if (ctl.clear)
        begin
            stopped_next = 1'b0;
            lat_deg_next = '0;
            lat_min_next = '0;
            lat_hun_next = '0;
            south_next   = 1'b0;
            lon_deg_next = '0;
            lon_min_next = '0;
            lon_hun_next = '0;
            west_next    = 1'b0;
        end
        else if (ctl.step)
        begin
            unique case (ctl.offset) inside
                OFF_LAT_DEG, OFF_LAT_DEG + 5'd1:
                begin
                    stopped_next = !take;
                    if (take)
                        lat_deg_next = 7'(dec_acc({3'd0, lat_deg_reg}, digit));
                end
                OFF_LAT_MIN, OFF_LAT_MIN + 5'd1:
                begin
                    stopped_next = !take;
                    if (take)
                        lat_min_next = 7'(dec_acc({3'd0, lat_min_reg}, digit));
                end
                OFF_LAT_HUN, OFF_LAT_HUN + 5'd1:
                begin
                    stopped_next = !take;
                    if (take)
                        lat_hun_next = 7'(dec_acc({3'd0, lat_hun_reg}, digit));
                end
                OFF_LAT_HEMI:
                    south_next = (data_byte == CHAR_SOUTH);
                OFF_LON_DEG, OFF_LON_DEG + 5'd1, OFF_LON_DEG + 5'd2:
                begin
                    stopped_next = !take;
                    if (take)
                        lon_deg_next = dec_acc(lon_deg_reg, digit);
                end
                OFF_LON_MIN, OFF_LON_MIN + 5'd1:
                begin
                    stopped_next = !take;
                    if (take)
                        lon_min_next = 7'(dec_acc({3'd0, lon_min_reg}, digit));
                end
                OFF_LON_HUN, OFF_LON_HUN + 5'd1:
                begin
                    stopped_next = !take;
                    if (take)
                        lon_hun_next = 7'(dec_acc({3'd0, lon_hun_reg}, digit));
                end
                OFF_LON_HEMI:
                    west_next = (data_byte == CHAR_WEST);
                default:
                begin
                    // separator and symbol bytes: nothing to decode
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stopped_reg <= 1'b0;
            lat_deg_reg <= '0;
            lat_min_reg <= '0;
            lat_hun_reg <= '0;
            south_reg   <= 1'b0;
            lon_deg_reg <= '0;
            lon_min_reg <= '0;
            lon_hun_reg <= '0;
            west_reg    <= 1'b0;
        end
        else
        begin
            stopped_reg <= stopped_next;
            lat_deg_reg <= lat_deg_next;
            lat_min_reg <= lat_min_next;
            lat_hun_reg <= lat_hun_next;
            south_reg   <= south_next;
            lon_deg_reg <= lon_deg_next;
            lon_min_reg <= lon_min_next;
            lon_hun_reg <= lon_hun_next;
            west_reg    <= west_next;
        end
    end

    assign lat_sec_prod = {3'd0, lat_hun_reg} * {7'd0, SEC_MUL};
    assign lon_sec_prod = {3'd0, lon_hun_reg} * {7'd0, SEC_MUL};

    assign lat_degrees = south_reg ? -$signed({1'b0, lat_deg_reg}) : $signed({1'b0, lat_deg_reg});
    assign lon_degrees = west_reg  ? -$signed({1'b0, lon_deg_reg}) : $signed({1'b0, lon_deg_reg});
    assign lat_minutes = lat_min_reg;
    assign lon_minutes = lon_min_reg;
    assign lat_seconds = lat_sec_prod[SEC_SHIFT +: 6];
    assign lon_seconds = lon_sec_prod[SEC_SHIFT +: 6];

endmodule
